FILE: rtl/core/refcounted_page_allocator_core_macros.svh
// Assertion macros shared by the page allocator RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef REFCOUNTED_PAGE_ALLOCATOR_CORE_MACROS_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_CORE_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define RCPA_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define RCPA_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/core/rcpa_pkg.sv
// Package for the page allocator: sizes, command and status codes, shared types.
// No dependencies; used by rcpa_exec and refcounted_page_allocator_core.
`timescale 1ns / 1ps
`default_nettype none

package rcpa_pkg;

    localparam int NUM_PAGES = 32768;
    localparam int PAGE_W    = $clog2(NUM_PAGES);
    localparam int FCNT_W    = $clog2(NUM_PAGES + 1);
    localparam int COUNT_W   = 16;

    localparam logic [FCNT_W-1:0]  FCNT_NUM  = FCNT_W'(NUM_PAGES);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_ADDREF = 2'd2,
        CMD_COPY   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK  = 2'd0,
        STAT_OOM = 2'd1,
        STAT_BAD = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_COPY2
    } state_t;

    // Item fields and lookup results captured at acceptance.
    typedef struct packed {
        cmd_t                cmd;
        logic [PAGE_W-1:0]   page;
        logic                managed;
        logic [COUNT_W-1:0]  cnt;
        logic [PAGE_W-1:0]   top_page;
        logic [FCNT_W-1:0]   free_count;
    } exec_in_t;

    // Decision of one command: result fields and state updates.
    typedef struct packed {
        logic [PAGE_W-1:0]   result_page;
        status_t             status;
        logic                need_copy;
        logic                released;
        logic                pop;
        logic                push;
        logic                cnt_we;
        logic [PAGE_W-1:0]   cnt_addr;
        logic [COUNT_W-1:0]  cnt_wdata;
        logic [COUNT_W-1:0]  defer_cnt;
    } exec_out_t;

    function automatic logic [FCNT_W-1:0] init_count(input logic [PAGE_W-1:0] first);
        logic [FCNT_W-1:0] fp;
        fp = FCNT_W'(first);
        init_count = (fp >= FCNT_NUM) ? '0 : (FCNT_NUM - fp);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rcpa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; holds the free stack and the reference counts.
`timescale 1ns / 1ps
`default_nettype none

module rcpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/core/rcpa_exec.sv
// Command decision logic: turns a looked-up count and stack top into a result
// and the memory and pointer updates. Depends on rcpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rcpa_exec (
    input  wire rcpa_pkg::exec_in_t  ein,
    output      rcpa_pkg::exec_out_t eout
);

    logic empty;

    assign empty = (ein.free_count == '0);

    always_comb
    begin
        eout             = '0;
        eout.status      = rcpa_pkg::STAT_OK;
        eout.cnt_addr    = ein.page;
        case (ein.cmd)
            rcpa_pkg::CMD_ALLOC:
            begin
                if (empty)
                begin
                    eout.status = rcpa_pkg::STAT_OOM;
                end
                else
                begin
                    eout.result_page = ein.top_page;
                    eout.pop         = 1'b1;
                    eout.cnt_we      = 1'b1;
                    eout.cnt_addr    = ein.top_page;
                    eout.cnt_wdata   = rcpa_pkg::COUNT_ONE;
                end
            end
            default:
            begin
                if (!ein.managed || ein.cnt == '0)
                begin
                    eout.status = rcpa_pkg::STAT_BAD;
                end
                else if (ein.cmd == rcpa_pkg::CMD_FREE)
                begin
                    eout.cnt_we    = 1'b1;
                    eout.cnt_wdata = ein.cnt - rcpa_pkg::COUNT_ONE;
                    if (ein.cnt == rcpa_pkg::COUNT_ONE && ein.free_count < rcpa_pkg::FCNT_NUM)
                    begin
                        eout.push     = 1'b1;
                        eout.released = 1'b1;
                    end
                end
                else if (ein.cmd == rcpa_pkg::CMD_ADDREF)
                begin
                    if (ein.cnt != rcpa_pkg::COUNT_MAX)
                    begin
                        eout.cnt_we    = 1'b1;
                        eout.cnt_wdata = ein.cnt + rcpa_pkg::COUNT_ONE;
                    end
                end
                else if (ein.cnt == rcpa_pkg::COUNT_ONE)
                begin
                    eout.result_page = ein.page;
                end
                else if (empty)
                begin
                    eout.status = rcpa_pkg::STAT_OOM;
                end
                else
                begin
                    eout.result_page = ein.top_page;
                    eout.need_copy   = 1'b1;
                    eout.pop         = 1'b1;
                    eout.cnt_we      = 1'b1;
                    eout.cnt_addr    = ein.top_page;
                    eout.cnt_wdata   = rcpa_pkg::COUNT_ONE;
                    eout.defer_cnt   = ein.cnt - rcpa_pkg::COUNT_ONE;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/refcounted_page_allocator_core.sv
// A transaction is accepted in IDLE; its result is registered when the execute state commits,
// which waits while the output is stalled. A new transaction is taken only in IDLE; a copy-and-
// dereference taking a new page adds COPY2, as the count RAM's single write port updates both pages.
// Reset: no clearing pass. A fill watermark marks untouched stack slots and
// counts, so the block takes a transaction in the first cycle after reset.
// Top level of the page allocator; depends on rcpa_pkg, rcpa_ram, rcpa_exec
// and refcounted_page_allocator_core_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "refcounted_page_allocator_core_macros.svh"

module refcounted_page_allocator_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [rcpa_pkg::PAGE_W-1:0]  cfg_data,
    input  wire logic                         in_valid,
    output      logic                         in_stall,
    input  wire logic [1:0]                   cmd,
    input  wire logic [rcpa_pkg::PAGE_W-1:0]  page,
    output      logic                         out_valid,
    input  wire logic                         out_stall,
    output      logic [rcpa_pkg::PAGE_W-1:0]  result_page,
    output      logic [1:0]                   status,
    output      logic                         need_copy,
    output      logic                         released
);

    localparam int PW = rcpa_pkg::PAGE_W;
    localparam int FW = rcpa_pkg::FCNT_W;
    localparam int CW = rcpa_pkg::COUNT_W;

    rcpa_pkg::state_t  state_reg, state_next;
    logic [PW-1:0]     first_page_reg;
    logic [FW-1:0]     free_count_reg, free_count_next;
    logic [FW-1:0]     min_count_reg, min_count_next;
    logic              out_valid_reg, out_valid_next;

    rcpa_pkg::cmd_t    cmd_reg;
    logic [PW-1:0]     page_reg;
    logic              managed_reg;
    logic              cnt_zero_reg;
    logic              stk_fresh_reg;
    logic [PW-1:0]     stk_init_reg;
    logic [CW-1:0]     defer_cnt_reg;

    logic [PW-1:0]     result_page_reg;
    rcpa_pkg::status_t status_reg;
    logic              need_copy_reg;
    logic              released_reg;

    logic              accept;
    logic              commit;
    logic              managed;
    logic [FW-1:0]     offset;
    logic [FW-1:0]     top_idx;
    logic [FW-1:0]     fcnt_dec;

    logic              cnt_we;
    logic [PW-1:0]     cnt_waddr;
    logic [CW-1:0]     cnt_wdata;
    logic [CW-1:0]     cnt_rdata;
    logic              stk_we;
    logic [PW-1:0]     stk_rdata;

    rcpa_pkg::exec_in_t  ein;
    rcpa_pkg::exec_out_t eout;

    // Lookup side: decode the incoming transaction against the watermark.
    assign managed  = (FW'(page) < rcpa_pkg::FCNT_NUM) && (page >= first_page_reg);
    assign offset   = FW'(page) - FW'(first_page_reg);
    assign top_idx  = free_count_reg - FW'(1);
    assign fcnt_dec = free_count_reg - FW'(1);

    rcpa_ram #(
        .WIDTH (CW),
        .DEPTH (rcpa_pkg::NUM_PAGES)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (accept),
        .raddr (page),
        .rdata (cnt_rdata)
    );

    rcpa_ram #(
        .WIDTH (PW),
        .DEPTH (rcpa_pkg::NUM_PAGES)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (free_count_reg[PW-1:0]),
        .wdata (page_reg),
        .re    (accept),
        .raddr (top_idx[PW-1:0]),
        .rdata (stk_rdata)
    );

    always_comb
    begin
        ein.cmd        = cmd_reg;
        ein.page       = page_reg;
        ein.managed    = managed_reg;
        ein.cnt        = cnt_zero_reg ? '0 : cnt_rdata;
        ein.top_page   = stk_fresh_reg ? stk_init_reg : stk_rdata;
        ein.free_count = free_count_reg;
    end

    rcpa_exec u_exec (
        .ein  (ein),
        .eout (eout)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rcpa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = rcpa_pkg::ST_EXEC;
                end
            end
            rcpa_pkg::ST_EXEC:
            begin
                if (commit)
                begin
                    state_next = eout.need_copy ? rcpa_pkg::ST_COPY2 : rcpa_pkg::ST_IDLE;
                end
            end
            rcpa_pkg::ST_COPY2:
            begin
                state_next = rcpa_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rcpa_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the state machine.
    always_comb
    begin
        in_stall  = 1'b1;
        accept    = 1'b0;
        commit    = 1'b0;
        cnt_we    = 1'b0;
        cnt_waddr = eout.cnt_addr;
        cnt_wdata = eout.cnt_wdata;
        stk_we    = 1'b0;
        case (state_reg)
            rcpa_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                accept   = in_valid;
            end
            rcpa_pkg::ST_EXEC:
            begin
                commit = !out_valid_reg || !out_stall;
                cnt_we = commit && eout.cnt_we;
                stk_we = commit && eout.push;
            end
            rcpa_pkg::ST_COPY2:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = page_reg;
                cnt_wdata = defer_cnt_reg;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        free_count_next = free_count_reg;
        min_count_next  = min_count_reg;
        out_valid_next  = out_valid_reg && out_stall;
        if (cfg_we)
        begin
            free_count_next = rcpa_pkg::init_count(cfg_data);
            min_count_next  = rcpa_pkg::init_count(cfg_data);
        end
        else if (commit)
        begin
            if (eout.pop)
            begin
                free_count_next = fcnt_dec;
                if (fcnt_dec < min_count_reg)
                begin
                    min_count_next = fcnt_dec;
                end
            end
            else if (eout.push)
            begin
                free_count_next = free_count_reg + FW'(1);
            end
        end
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rcpa_pkg::ST_IDLE;
            first_page_reg <= '0;
            free_count_reg <= rcpa_pkg::init_count('0);
            min_count_reg  <= rcpa_pkg::init_count('0);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            free_count_reg <= free_count_next;
            min_count_reg  <= min_count_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                first_page_reg <= cfg_data;
            end
        end
    end

    // Hold the transaction and its lookup flags for the execute state; capture the result at commit.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg       <= rcpa_pkg::cmd_t'(cmd);
            page_reg      <= page;
            managed_reg   <= managed;
            cnt_zero_reg  <= offset < min_count_reg;
            stk_fresh_reg <= top_idx < min_count_reg;
            stk_init_reg  <= first_page_reg + top_idx[PW-1:0];
        end
        if (commit)
        begin
            defer_cnt_reg   <= eout.defer_cnt;
            result_page_reg <= eout.result_page;
            status_reg      <= eout.status;
            need_copy_reg   <= eout.need_copy;
            released_reg    <= eout.released;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_page = result_page_reg;
    assign status      = status_reg;
    assign need_copy   = need_copy_reg;
    assign released    = released_reg;

    `RCPA_ASSERT(a_fcnt_range, free_count_reg <= rcpa_pkg::FCNT_NUM,
        "free count above page count")
    `RCPA_ASSERT(a_mark_below, min_count_reg <= free_count_reg, "watermark above free count")
    `RCPA_ASSERT(a_accept_exec, accept |=> state_reg == rcpa_pkg::ST_EXEC,
        "accepted transaction not executed")
    `RCPA_ASSERT(a_copy2_result,
        (state_reg == rcpa_pkg::ST_COPY2) |-> (out_valid_reg && need_copy_reg),
        "deferred write without copy result")
    `RCPA_NEVER(a_copy_status,
        out_valid_reg && need_copy_reg && (status_reg != rcpa_pkg::STAT_OK || released_reg),
        "copy flagged with bad status or release")

endmodule

`default_nettype wire
